// File: hw/rtl/hmv_pkg.sv
package hmv_pkg;

  localparam int MaxRes    = 256;
  localparam int AddrW     = 16;
  localparam int StoreDepth = MaxRes * MaxRes;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_VERTEX = 2'd1;
  localparam logic [1:0] OP_CELL   = 2'd2;

  localparam logic [1:0] REG_RES   = 2'd0;
  localparam logic [1:0] REG_EXT   = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RD,
    ST_RDWAIT,
    ST_MUL,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_OUT,
    ST_CELL0,
    ST_CELL1
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] height_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [15:0] norm_x;
    logic [15:0] norm_y;
    logic [15:0] norm_z;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [15:0] tri_a;
    logic [15:0] tri_b;
    logic [15:0] tri_c;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_item_t;

endpackage

// File: hw/rtl/hmv_stream_if.sv
interface hmv_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/hmv_ram.sv
module hmv_ram #(
  parameter int Width = 16,
  parameter int Depth = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/heightmap_mesh_vertex_engine.sv
// heightmap_mesh_vertex_engine
// Channels: in (opcode, col, row, height_in), out (vertex/triangle results,
// last marks the final result of a request), cfg (index, data register writes).
// One transaction in at a time; in_ready is high only while the sequencer idles
// and the output register is empty.
// Write: no result. Cell: the first result loads into the output register from ST_CELL0,
// entered after accept; the second loads on the cycle the first is taken.
// Vertex: one shared sequencer computes the result: 5 reads from the single height RAM
// port, 5 products on a 33x33 multiplier, a bit-serial square root and a bit-serial
// restoring divider run for normal, positions and texture (the normal divisions are
// not run with zero scale). The next transaction is taken once the output register
// has emptied after the result leaves.
// Reset: registers go to resolution 64, extent 1.0, scale 1.0; then a clearing
// pass writes zero to all 65536 RAM entries before in_ready rises.
// Configuration is taken at any time. When out_ready is low the result holds in
// the output register and the sequencer waits.
module heightmap_mesh_vertex_engine
  import hmv_pkg::*;
(
  input logic clk,
  input logic rst_n,
  hmv_stream_if.sink   in_ch,
  hmv_stream_if.source out_ch,
  hmv_stream_if.sink   cfg_ch
);

  state_t state_r, state_nxt;

  logic [8:0]  res_r;
  logic [23:0] ext_r;
  logic signed [15:0] scl_r;

  // clamped resolution
  logic [8:0] r_eff;
  always_comb begin
    r_eff = res_r;
    if (res_r < 9'd2) r_eff = 9'd2;
    if (res_r > 9'(MaxRes)) r_eff = 9'(MaxRes);
  end
  logic [8:0] rm1;
  assign rm1 = r_eff - 9'd1;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= 9'd64;
      ext_r <= 24'd256;
      scl_r <= 16'sd256;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        REG_RES:   res_r <= cfg_ch.data.data[8:0];
        REG_EXT:   ext_r <= (cfg_ch.data.data[23:0] == 24'd0) ? 24'd256
                                                              : cfg_ch.data.data[23:0];
        REG_SCALE: scl_r <= cfg_ch.data.data[15:0];
        default: ;
      endcase
    end
  end

  // RAM
  logic        ram_we;
  logic [15:0] ram_waddr, ram_raddr, ram_wdata, ram_rdata;
  hmv_ram #(.Width(16), .Depth(StoreDepth)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [16:0] clr_r, clr_nxt;
  logic [7:0]  x_r, x_nxt, z_r, z_nxt;
  logic [2:0]  idx_r, idx_nxt;        // read / op index
  logic signed [15:0] h_r [5];        // center, left, right, down, up
  logic signed [15:0] h_nxt [5];
  logic [3:0]  step_r, step_nxt;      // multiply / divide job index
  logic [5:0]  bit_r, bit_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic [63:0] acc_r, acc_nxt;        // square sum / sqrt remainder
  logic [63:0] root_r, root_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [47:0] num_r, num_nxt;
  logic [47:0] den_r, den_nxt;
  logic [47:0] quo_r, quo_nxt;
  logic        neg_r, neg_nxt;
  logic signed [31:0] xp_r, xp_nxt, zp_r, zp_nxt;
  out_item_t   o_r, o_nxt;
  logic        ov_r, ov_nxt;

  // shared 33x33 signed multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // neighbour coordinates for read idx
  logic [7:0] rx, rz;
  always_comb begin
    rx = x_r; rz = z_r;
    case (idx_r)
      3'd1: rx = (x_r == 8'd0) ? 8'd0 : x_r - 8'd1;
      3'd2: rx = (9'(x_r) >= rm1) ? rm1[7:0] : x_r + 8'd1;
      3'd3: rz = (z_r == 8'd0) ? 8'd0 : z_r - 8'd1;
      3'd4: rz = (9'(z_r) >= rm1) ? rm1[7:0] : z_r + 8'd1;
      default: ;
    endcase
  end
  logic [16:0] lin;
  assign lin = 17'(rz) * 17'(r_eff) + 17'(rx);

  logic signed [16:0] abs_s;
  assign abs_s = scl_r[15] ? -17'(scl_r) : 17'(scl_r);
  logic signed [16:0] da, dc;
  assign da = 17'(h_r[1]) - 17'(h_r[2]);
  assign dc = 17'(h_r[3]) - 17'(h_r[4]);

  // sqrt step
  logic [63:0] sq_bit, sq_try;
  assign sq_bit = 64'd1 << {bit_r, 1'b0};
  assign sq_try = root_r + sq_bit;

  logic [48:0] dv_try;
  assign dv_try = {rem_r[47:0], num_r[47]} - {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r; x_nxt = x_r; z_nxt = z_r; idx_nxt = idx_r;
    for (int i = 0; i < 5; i++) h_nxt[i] = h_r[i];
    step_nxt = step_r; bit_nxt = bit_r; prod_nxt = prod_r; acc_nxt = acc_r;
    root_nxt = root_r; rem_nxt = rem_r; num_nxt = num_r; den_nxt = den_r;
    quo_nxt = quo_r; neg_nxt = neg_r; xp_nxt = xp_r; zp_nxt = zp_r;
    o_nxt = o_r; ov_nxt = ov_r;
    ram_we = 1'b0; ram_waddr = 16'd0; ram_wdata = 16'd0; ram_raddr = lin[15:0];
    mul_a = '0; mul_b = '0;
    in_ch.ready = 1'b0;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1; ram_waddr = clr_r[15:0];
        clr_nxt = clr_r + 17'd1;
        if (clr_r == 17'(StoreDepth - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ch.ready = !ov_r;
        if (in_ch.valid && !ov_r) begin
          case (in_ch.data.opcode)
            OP_WRITE: begin
              if (9'(in_ch.data.col) < r_eff && 9'(in_ch.data.row) < r_eff) begin
                ram_we = 1'b1;
                ram_waddr = 16'(17'(in_ch.data.row) * 17'(r_eff) + 17'(in_ch.data.col));
                ram_wdata = in_ch.data.height_in;
              end
            end
            OP_VERTEX: begin
              x_nxt = (9'(in_ch.data.col) > rm1) ? rm1[7:0] : in_ch.data.col;
              z_nxt = (9'(in_ch.data.row) > rm1) ? rm1[7:0] : in_ch.data.row;
              idx_nxt = 3'd0;
              state_nxt = ST_RD;
            end
            OP_CELL: begin
              x_nxt = (9'(in_ch.data.col) > rm1 - 9'd1) ? 8'(rm1 - 9'd1) : in_ch.data.col;
              z_nxt = (9'(in_ch.data.row) > rm1 - 9'd1) ? 8'(rm1 - 9'd1) : in_ch.data.row;
              state_nxt = ST_CELL0;
            end
            default: ;
          endcase
        end
      end
      ST_CELL0: begin
        if (!ov_r || out_ch.ready) begin
          o_nxt = '0;
          o_nxt.tri_a = 16'(17'(z_r) * 17'(r_eff) + 17'(x_r));
          o_nxt.tri_b = o_nxt.tri_a + 16'(r_eff);
          o_nxt.tri_c = o_nxt.tri_a + 16'd1;
          ov_nxt = 1'b1;
          state_nxt = ST_CELL1;
        end
      end
      ST_CELL1: begin
        if (!ov_r || out_ch.ready) begin
          o_nxt.tri_a = o_r.tri_c;
          o_nxt.tri_c = o_r.tri_b + 16'd1;
          o_nxt.last = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_RD: state_nxt = ST_RDWAIT;
      ST_RDWAIT: begin
        h_nxt[idx_r] = ram_rdata;
        if (idx_r == 3'd4) begin
          step_nxt = 4'd0; state_nxt = ST_MUL;
        end else begin
          idx_nxt = idx_r + 3'd1; state_nxt = ST_RD;
        end
      end
      ST_MUL: begin
        // step 0: h*s  1: a*|s|  2: c*|s|  3: x*x 4: z*z
        case (step_r)
          4'd0: begin mul_a = 33'(h_r[0]); mul_b = 33'(scl_r); end
          4'd1: begin mul_a = 33'(da); mul_b = 33'(abs_s); end
          4'd2: begin mul_a = 33'(dc); mul_b = 33'(abs_s); end
          4'd3: begin mul_a = 33'(xp_r); mul_b = 33'(xp_r); end
          default: begin mul_a = 33'(zp_r); mul_b = 33'(zp_r); end
        endcase
        prod_nxt = 64'(mul_p);
        step_nxt = step_r + 4'd1;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        case (step_r)
          4'd1: begin
            // pos_y: round(p/4096), saturate
            begin
              logic [63:0] m;
              logic [63:0] q;
              logic signed [63:0] v;
              m = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
              q = (m + 64'd2048) >> 12;
              v = prod_r[63] ? -$signed(q) : $signed(q);
              if (v > 64'sd2147483647) o_nxt.pos_y = 32'h7fffffff;
              else if (v < -64'sd2147483648) o_nxt.pos_y = 32'h80000000;
              else o_nxt.pos_y = v[31:0];
            end
            state_nxt = ST_MUL;
          end
          4'd2: begin xp_nxt = prod_r[31:0]; state_nxt = ST_MUL; end
          4'd3: begin zp_nxt = prod_r[31:0]; state_nxt = ST_MUL; end
          4'd4: begin acc_nxt = 64'(prod_r) + (64'd1 << 42); state_nxt = ST_MUL; end
          default: begin
            acc_nxt = acc_r + 64'(prod_r);
            root_nxt = '0; bit_nxt = 6'd31; rem_nxt = '0;
            state_nxt = ST_SQRT;
          end
        endcase
      end
      ST_SQRT: begin
        // digit recurrence, one root bit per cycle
        if (acc_r >= sq_try) begin
          acc_nxt = acc_r - sq_try;
          root_nxt = (root_r >> 1) + sq_bit;
        end else begin
          root_nxt = root_r >> 1;
        end
        if (bit_r == 6'd0) begin
          step_nxt = 4'd0; bit_nxt = 6'd0;
          state_nxt = ST_DIV;
        end else begin
          bit_nxt = bit_r - 6'd1;
        end
      end
      ST_DIV: begin
        // jobs: 0 nx,1 ny,2 nz,3 px,4 pz,5 u,6 v ; bit_r==0 means load
        if (bit_r == 6'd0) begin
          logic signed [47:0] n;
          logic [47:0] m, d;
          n = '0; d = 48'd1;
          case (step_r)
            4'd0: begin n = 48'(xp_r) <<< 14; d = 48'(root_r); end
            4'd1: begin n = scl_r[15] ? -(48'sd1 <<< 35) : (48'sd1 <<< 35); d = 48'(root_r); end
            4'd2: begin n = 48'(zp_r) <<< 14; d = 48'(root_r); end
            4'd3: begin
              mul_a = 33'($signed({1'b0, x_r, 1'b0}) - $signed({2'b0, rm1}));
              mul_b = 33'($signed({1'b0, ext_r}));
              n = 48'(mul_p); d = 48'({rm1, 1'b0});
            end
            4'd4: begin
              mul_a = 33'($signed({1'b0, z_r, 1'b0}) - $signed({2'b0, rm1}));
              mul_b = 33'($signed({1'b0, ext_r}));
              n = 48'(mul_p); d = 48'({rm1, 1'b0});
            end
            4'd5: begin n = 48'(x_r) << 17; d = 48'({rm1, 1'b0}); end
            default: begin n = 48'(z_r) << 17; d = 48'({rm1, 1'b0}); end
          endcase
          if (scl_r == 16'sd0 && step_r < 4'd3) begin
            o_nxt.norm_x = '0; o_nxt.norm_y = 16'd16384; o_nxt.norm_z = '0;
            step_nxt = 4'd3;
          end else begin
            neg_nxt = n[47];
            m = n[47] ? 48'(-n) : 48'(n);
            num_nxt = m + (d >> 1);
            den_nxt = d; rem_nxt = '0; quo_nxt = '0;
            bit_nxt = 6'd48;
          end
        end else begin
          if (!dv_try[48]) begin
            rem_nxt = 64'(dv_try[47:0]); quo_nxt = {quo_r[46:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[62:0], num_r[47]}; quo_nxt = {quo_r[46:0], 1'b0};
          end
          num_nxt = num_r << 1;
          bit_nxt = bit_r - 6'd1;
          if (bit_r == 6'd1) begin
            logic [47:0] qq, sq;
            qq = quo_nxt;
            sq = neg_r ? -qq : qq;
            case (step_r)
              4'd0: o_nxt.norm_x = sq[15:0];
              4'd1: o_nxt.norm_y = sq[15:0];
              4'd2: o_nxt.norm_z = sq[15:0];
              4'd3: o_nxt.pos_x = sq[31:0];
              4'd4: o_nxt.pos_z = sq[31:0];
              4'd5: o_nxt.tex_u = qq[16:0];
              default: o_nxt.tex_v = 17'd65536 - qq[16:0];
            endcase
            step_nxt = step_r + 4'd1;
            if (step_r == 4'd6) state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (!ov_r || out_ch.ready) begin
          o_nxt.tri_a = '0; o_nxt.tri_b = '0; o_nxt.tri_c = '0; o_nxt.last = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; z_r <= z_nxt; idx_r <= idx_nxt;
    for (int i = 0; i < 5; i++) h_r[i] <= h_nxt[i];
    step_r <= step_nxt; bit_r <= bit_nxt; prod_r <= prod_nxt; acc_r <= acc_nxt;
    root_r <= root_nxt; rem_r <= rem_nxt; num_r <= num_nxt; den_r <= den_nxt;
    quo_r <= quo_nxt; neg_r <= neg_nxt; xp_r <= xp_nxt; zp_r <= zp_nxt;
    o_r <= o_nxt;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data = o_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> ov_r) else $error("result dropped");
  a_cell_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CELL1 && ov_r) |-> !o_r.last) else $error("cell order");

endmodule

// File: tb/tb_heightmap_mesh_vertex_engine.sv
module tb_heightmap_mesh_vertex_engine;
  import hmv_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CycleLimit = 3000000;
  localparam int PhaseCount = 7;

  class mesh_scoreboard;
    shortint   heights[StoreDepth];
    int        res_reg;
    longint    extent_reg;
    longint    scale_reg;
    out_item_t expected_q[$];
    int        errors;
    int        results_seen;
    int        vertex_count;
    int        cell_count;

    function new();
      foreach (heights[i]) heights[i] = 0;
      res_reg = 64;
      extent_reg = 256;
      scale_reg = 256;
      errors = 0;
      results_seen = 0;
      vertex_count = 0;
      cell_count = 0;
    endfunction

    function void report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void configure(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_RES: res_reg = int'(value[8:0]);
        REG_EXT: begin
          extent_reg = longint'(value[23:0]);
          if (extent_reg == 0) extent_reg = 256;
        end
        REG_SCALE: scale_reg = longint'($signed(value[15:0]));
        default: ;
      endcase
    endfunction

    function int grid_size();
      if (res_reg < 2) return 2;
      if (res_reg > MaxRes) return MaxRes;
      return res_reg;
    endfunction

    function longint round_div(longint n, longint d);
      longint m;
      longint q;
      m = (n < 0) ? -n : n;
      q = (m + d / 2) / d;
      return (n < 0) ? -q : q;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v = v - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function longint sample_at(int x, int z, int r);
      if (x < 0) x = 0;
      if (x > r - 1) x = r - 1;
      if (z < 0) z = 0;
      if (z > r - 1) z = r - 1;
      return longint'(heights[z * r + x]);
    endfunction

    function void note_input(in_item_t it);
      int r;
      int x;
      int z;
      longint rm1;
      longint py;
      longint nx;
      longint ny;
      longint nz;
      longint mag;
      longint xp;
      longint zp;
      longint yp;
      longint unsigned sq;
      longint unsigned len;
      int t;
      out_item_t o;
      r = grid_size();
      rm1 = r - 1;
      x = it.col;
      z = it.row;
      o = '0;
      case (it.opcode)
        OP_WRITE: begin
          if (x < r && z < r) heights[z * r + x] = shortint'(it.height_in);
        end
        OP_VERTEX: begin
          vertex_count++;
          if (x > rm1) x = int'(rm1);
          if (z > rm1) z = int'(rm1);
          o.pos_x = 32'(round_div((2 * longint'(x) - rm1) * extent_reg, 2 * rm1));
          o.pos_z = 32'(round_div((2 * longint'(z) - rm1) * extent_reg, 2 * rm1));
          py = round_div(sample_at(x, z, r) * scale_reg, 4096);
          if (py > 64'sd2147483647) py = 64'sd2147483647;
          if (py < -64'sd2147483648) py = -64'sd2147483648;
          o.pos_y = 32'(py);
          nx = 0;
          ny = 16384;
          nz = 0;
          if (scale_reg != 0) begin
            mag = (scale_reg < 0) ? -scale_reg : scale_reg;
            xp = (sample_at(x - 1, z, r) - sample_at(x + 1, z, r)) * mag;
            zp = (sample_at(x, z - 1, r) - sample_at(x, z + 1, r)) * mag;
            yp = (scale_reg > 0) ? (64'sd1 << 21) : -(64'sd1 << 21);
            sq = longint'(xp * xp) + longint'(zp * zp) + (64'd1 << 42);
            len = int_sqrt(sq);
            nx = round_div(xp * 16384, longint'(len));
            ny = round_div(yp * 16384, longint'(len));
            nz = round_div(zp * 16384, longint'(len));
          end
          o.norm_x = 16'(nx);
          o.norm_y = 16'(ny);
          o.norm_z = 16'(nz);
          o.tex_u = 17'((longint'(x) * 131072 + rm1) / (2 * rm1));
          o.tex_v = 17'(65536 - (longint'(z) * 131072 + rm1) / (2 * rm1));
          o.last = 1'b1;
          expected_q.push_back(o);
        end
        OP_CELL: begin
          cell_count++;
          if (x > r - 2) x = r - 2;
          if (z > r - 2) z = r - 2;
          t = z * r + x;
          o.tri_a = 16'(t);
          o.tri_b = 16'(t + r);
          o.tri_c = 16'(t + 1);
          expected_q.push_back(o);
          o.tri_a = 16'(t + 1);
          o.tri_b = 16'(t + r);
          o.tri_c = 16'(t + r + 1);
          o.last = 1'b1;
          expected_q.push_back(o);
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.pos_x !== want.pos_x)
        report($sformatf("pos_x got %h want %h", got.pos_x, want.pos_x));
      if (got.pos_y !== want.pos_y)
        report($sformatf("pos_y got %h want %h", got.pos_y, want.pos_y));
      if (got.pos_z !== want.pos_z)
        report($sformatf("pos_z got %h want %h", got.pos_z, want.pos_z));
      if (got.norm_x !== want.norm_x)
        report($sformatf("norm_x got %h want %h", got.norm_x, want.norm_x));
      if (got.norm_y !== want.norm_y)
        report($sformatf("norm_y got %h want %h", got.norm_y, want.norm_y));
      if (got.norm_z !== want.norm_z)
        report($sformatf("norm_z got %h want %h", got.norm_z, want.norm_z));
      if (got.tex_u !== want.tex_u)
        report($sformatf("tex_u got %h want %h", got.tex_u, want.tex_u));
      if (got.tex_v !== want.tex_v)
        report($sformatf("tex_v got %h want %h", got.tex_v, want.tex_v));
      if (got.tri_a !== want.tri_a)
        report($sformatf("tri_a got %h want %h", got.tri_a, want.tri_a));
      if (got.tri_b !== want.tri_b)
        report($sformatf("tri_b got %h want %h", got.tri_b, want.tri_b));
      if (got.tri_c !== want.tri_c)
        report($sformatf("tri_c got %h want %h", got.tri_c, want.tri_c));
      if (got.last !== want.last)
        report($sformatf("last got %b want %b", got.last, want.last));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  bit   idle_enable;
  int   out_stall = 0;

  hmv_stream_if #(.T(in_item_t))  in_if();
  hmv_stream_if #(.T(out_item_t)) out_if();
  hmv_stream_if #(.T(cfg_item_t)) cfg_if();

  mesh_scoreboard sb;

  heightmap_mesh_vertex_engine dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if.sink),
    .out_ch(out_if.source),
    .cfg_ch(cfg_if.sink)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_input(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
    end
  end

  // receiver stalls in bursts
  always @(negedge clk) begin
    if (!idle_enable) begin
      out_stall <= 0;
      out_if.ready <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= $urandom_range(0, 11);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_item(logic [1:0] op, int col, int row, logic [15:0] h);
    in_item_t it;
    it.opcode = op;
    it.col = 8'(col);
    it.row = 8'(row);
    it.height_in = h;
    in_if.valid <= 1'b1;
    in_if.data <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_item_t c;
    c.index = idx;
    c.data = value;
    cfg_if.valid <= 1'b1;
    cfg_if.data <= c;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.configure(idx, value);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    // quiet gap before the next configuration write or request
    repeat (200) @(negedge clk);
  endtask

  task automatic random_item();
    int r;
    int pick;
    int col;
    int row;
    logic [1:0] op;
    r = sb.grid_size();
    pick = $urandom_range(0, 99);
    if (pick < 40) op = OP_WRITE;
    else if (pick < 75) op = OP_VERTEX;
    else if (pick < 95) op = OP_CELL;
    else op = OP_UNUSED;
    if ($urandom_range(0, 9) < 8) begin
      col = $urandom_range(0, r - 1);
      row = $urandom_range(0, r - 1);
    end else begin
      col = $urandom_range(0, 255);
      row = $urandom_range(0, 255);
    end
    send_item(op, col, row, 16'($urandom));
  endtask

  task automatic directed_items();
    send_item(OP_WRITE, 0, 0, 16'h7fff);
    send_item(OP_WRITE, 1, 0, 16'h8000);
    send_item(OP_WRITE, 0, 1, 16'h7fff);
    send_item(OP_WRITE, 63, 63, 16'h8000);
    send_item(OP_WRITE, 62, 63, 16'h7fff);
    send_item(OP_WRITE, 64, 5, 16'h1234);
    send_item(OP_WRITE, 5, 255, 16'h4321);
    send_item(OP_WRITE, 10, 10, 16'hffff);
    send_item(OP_VERTEX, 0, 0, 16'h0);
    send_item(OP_VERTEX, 1, 0, 16'hffff);
    send_item(OP_VERTEX, 63, 63, 16'h0);
    send_item(OP_VERTEX, 255, 255, 16'h0);
    send_item(OP_VERTEX, 10, 10, 16'h0);
    send_item(OP_VERTEX, 64, 5, 16'h0);
    send_item(OP_CELL, 0, 0, 16'h0);
    send_item(OP_CELL, 62, 62, 16'h0);
    send_item(OP_CELL, 255, 255, 16'hffff);
    send_item(OP_CELL, 63, 0, 16'h0);
    send_item(OP_UNUSED, 3, 3, 16'h5555);
    send_item(OP_UNUSED, 255, 255, 16'haaaa);
  endtask

  int          phase_res[PhaseCount]   = '{2, 256, 0, 511, 17, 256, 64};
  logic [31:0] phase_ext[PhaseCount]   = '{32'd256, 32'hffffff, 32'd0, 32'd1,
                                           32'd12345, 32'd300, 32'hff000100};
  logic [31:0] phase_scale[PhaseCount] = '{32'h0100, 32'h8000, 32'h7fff, 32'h0000,
                                           32'hffff, 32'h0064, 32'h1234};

  initial begin
    sb = new();
    idle_enable = 1'b1;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_items();
    drain();

    for (int p = 0; p < PhaseCount; p++) begin
      write_reg(REG_RES, 32'(phase_res[p]));
      write_reg(REG_EXT, phase_ext[p]);
      write_reg(REG_SCALE, phase_scale[p]);
      if (p == PhaseCount - 1) idle_enable = 1'b0;
      for (int i = 0; i < 230; i++) begin
        random_item();
        if (p == 2 && i == 100) drain();
      end
      if (p == 3) begin
        send_item(OP_VERTEX, 0, 0, 16'h0);
        send_item(OP_VERTEX, 255, 255, 16'h0);
      end
      drain();
    end

    $display("Covered %0d vertex and %0d cell requests, %0d results, over %0d settings",
             sb.vertex_count, sb.cell_count, sb.results_seen, PhaseCount + 1);
    $display("Resolutions from clamped low to clamped high, extreme extents and scales");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/hmv_pkg.sv
hw/rtl/hmv_stream_if.sv
hw/rtl/hmv_ram.sv
hw/rtl/heightmap_mesh_vertex_engine.sv
tb/tb_heightmap_mesh_vertex_engine.sv
